[hdl/sser_pkg.sv]
// Shared types and constants for the SPI slave event responder.
// No dependencies; sser_csr, sser_ctrl and the top level refer to this package.

package sser_pkg;

   // request actions
   localparam logic [1:0] ACT_RX      = 2'd0;
   localparam logic [1:0] ACT_EVENT   = 2'd1;
   localparam logic [1:0] ACT_ENCODER = 2'd2;

   // transaction modes
   localparam logic [2:0] MODE_IDLE       = 3'd0;
   localparam logic [2:0] MODE_SIMPLE     = 3'd1;
   localparam logic [2:0] MODE_LED        = 3'd2;
   localparam logic [2:0] MODE_LCD_TOP    = 3'd3;
   localparam logic [2:0] MODE_LCD_BOTTOM = 3'd4;
   localparam logic [2:0] MODE_DIP        = 3'd5;

   // data bytes that follow each frame command
   localparam logic [4:0] LED_BYTES = 5'd2;
   localparam logic [4:0] LCD_BYTES = 5'd16;

   // encoder ids and the event codes they map to
   localparam logic [2:0] ENC_ID_0   = 3'd0;
   localparam logic [2:0] ENC_ID_1   = 3'd2;
   localparam logic [2:0] ENC_ID_2   = 3'd4;
   localparam logic [3:0] ENC_CODE_0 = 4'd13;
   localparam logic [3:0] ENC_CODE_1 = 4'd14;
   localparam logic [3:0] ENC_CODE_2 = 4'd15;

   // configuration register indexes
   localparam logic [2:0] CSR_CMD_SIMPLE     = 3'd0;
   localparam logic [2:0] CSR_CMD_LED        = 3'd1;
   localparam logic [2:0] CSR_CMD_LCD_TOP    = 3'd2;
   localparam logic [2:0] CSR_CMD_LCD_BOTTOM = 3'd3;
   localparam logic [2:0] CSR_CMD_DIP        = 3'd4;

   typedef struct packed {
      logic [7:0] simple;
      logic [7:0] led;
      logic [7:0] lcd_top;
      logic [7:0] lcd_bottom;
      logic [7:0] dip;
   } cmd_set_type;

endpackage

[hdl/sser_if.sv]
// Request and response channel interfaces of the SPI slave event responder.
// Depends on nothing; carries valid, ready and the payload of each channel.

interface sser_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] rx_byte;
   logic [7:0] event_byte;
   logic [2:0] encoder_id;
   logic [3:0] encoder_count;
   logic [7:0] dip_value;

   modport source (output valid, action, rx_byte, event_byte, encoder_id,
                   encoder_count, dip_value, input ready);
   modport sink (input valid, action, rx_byte, event_byte, encoder_id,
                 encoder_count, dip_value, output ready);
endinterface

interface sser_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_load;
   logic [7:0] tx_byte;
   logic       store_valid;
   logic [3:0] store_index;
   logic [7:0] store_byte;
   logic [1:0] frame_done;
   logic       event_dropped;

   modport source (output valid, tx_load, tx_byte, store_valid, store_index,
                   store_byte, frame_done, event_dropped, input ready);
   modport sink (input valid, tx_load, tx_byte, store_valid, store_index,
                 store_byte, frame_done, event_dropped, output ready);
endinterface

[hdl/spi_slave_event_responder.sv]
// Top level of the SPI slave event responder.
// Depends on sser_pkg, sser_if, sser_csr, sser_stack_mem and sser_ctrl.

// Each request (a byte received from the SPI master, a key event push or an
// encoder push) produces exactly one response in the cycle after it is taken,
// and a new request is taken every cycle while the response side keeps up; a
// waiting response holds and stalls further requests. The response register
// lies between request and response; the registered read of the event stack
// memory, which holds both double-buffered stacks of STACK_DEPTH bytes, lands
// in the same cycle. The user must write command bytes through the csr_ port
// only while no request is in flight; the block itself does not enforce this.

module spi_slave_event_responder #(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   sser_req_if.sink   req,
   sser_rsp_if.source rsp,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   sser_pkg::cmd_set_type cmds;
   logic                  mem_we;
   logic [IDX_W:0]        mem_waddr;
   logic [7:0]            mem_wdata;
   logic                  mem_re;
   logic [IDX_W:0]        mem_raddr;
   logic [7:0]            mem_rdata;

   sser_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmds      (cmds)
   );

   sser_stack_mem #(
      .ADDR_W (IDX_W + 1)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   sser_ctrl #(
      .STACK_DEPTH (STACK_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmds      (cmds),
      .req       (req),
      .rsp       (rsp),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule

[hdl/sser_csr.sv]
// Command byte registers of the SPI slave event responder.
// Depends on sser_pkg for the register indexes and the command set struct.

module sser_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   output sser_pkg::cmd_set_type cmds
);

   sser_pkg::cmd_set_type cmds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmds_ff.simple     <= 8'd1;
         cmds_ff.led        <= 8'd2;
         cmds_ff.lcd_top    <= 8'd3;
         cmds_ff.lcd_bottom <= 8'd4;
         cmds_ff.dip        <= 8'd5;
      end else if (csr_we) begin
         case (csr_index)
            sser_pkg::CSR_CMD_SIMPLE:     cmds_ff.simple     <= csr_wdata;
            sser_pkg::CSR_CMD_LED:        cmds_ff.led        <= csr_wdata;
            sser_pkg::CSR_CMD_LCD_TOP:    cmds_ff.lcd_top    <= csr_wdata;
            sser_pkg::CSR_CMD_LCD_BOTTOM: cmds_ff.lcd_bottom <= csr_wdata;
            sser_pkg::CSR_CMD_DIP:        cmds_ff.dip        <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cmds = cmds_ff;

endmodule

[hdl/sser_stack_mem.sv]
// Event stack storage: both stacks in one memory, the stack select in the
// address MSB. One write and one registered read per cycle; uses no package.

module sser_stack_mem #(
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [7:0]        wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [7:0]        rdata
);

   logic [7:0] mem [2**ADDR_W];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/sser_ctrl.sv]
// Request decode, stack bookkeeping and response register of the responder.
// Depends on sser_pkg and the channel interfaces; drives sser_stack_mem.

module sser_ctrl #(
   parameter int STACK_DEPTH = 32,
   parameter int IDX_W = $clog2(STACK_DEPTH),
   parameter int CNT_W = $clog2(STACK_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sser_pkg::cmd_set_type cmds,
   sser_req_if.sink              req,
   sser_rsp_if.source            rsp,
   output logic                  mem_we,
   output logic [IDX_W:0]        mem_waddr,
   output logic [7:0]            mem_wdata,
   output logic                  mem_re,
   output logic [IDX_W:0]        mem_raddr,
   input  logic [7:0]            mem_rdata
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   logic [2:0]       mode_ff, mode_in;
   logic [4:0]       bytes_left_ff, bytes_left_in;
   logic             side_ff, side_in;     // 1: stack A takes pushes
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0] cnt_b_ff, cnt_b_in;

   logic             valid_ff;
   logic             tx_load_ff, tx_load_in;
   logic [7:0]       tx_ff, tx_in;
   logic             from_mem_ff, from_mem_in;
   logic             st_valid_ff, st_valid_in;
   logic [3:0]       st_idx_ff, st_idx_in;
   logic [7:0]       st_byte_ff, st_byte_in;
   logic [1:0]       done_ff, done_in;
   logic             dropped_ff, dropped_in;

   logic             accept;
   logic [CNT_W-1:0] wr_cnt, rd_cnt, wr_new, rd_new;
   logic [CNT_W-1:0] wr_dec, rd_dec;
   logic [4:0]       bl_dec;
   logic [7:0]       push_val;
   logic             push_req, swap_pop, pop;
   logic             do_we, do_re;
   logic [IDX_W:0]   raddr;

   assign req.ready = !valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;

   assign wr_cnt = side_ff ? cnt_a_ff : cnt_b_ff;
   assign rd_cnt = side_ff ? cnt_b_ff : cnt_a_ff;
   assign wr_dec = wr_cnt - CNT_ONE;
   assign rd_dec = rd_cnt - CNT_ONE;
   assign bl_dec = (bytes_left_ff != 5'd0) ? bytes_left_ff - 5'd1 : bytes_left_ff;

   always_comb begin
      push_val = 8'd0;
      case (req.encoder_id)
         sser_pkg::ENC_ID_0: push_val = {req.encoder_count, sser_pkg::ENC_CODE_0};
         sser_pkg::ENC_ID_1: push_val = {req.encoder_count, sser_pkg::ENC_CODE_1};
         sser_pkg::ENC_ID_2: push_val = {req.encoder_count, sser_pkg::ENC_CODE_2};
         default:            push_val = 8'd0;
      endcase
      if (req.action == sser_pkg::ACT_EVENT) begin
         push_val = req.event_byte;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      bytes_left_in = bytes_left_ff;
      tx_load_in    = 1'b0;
      tx_in         = 8'd0;
      from_mem_in   = 1'b0;
      st_valid_in   = 1'b0;
      st_idx_in     = 4'd0;
      st_byte_in    = 8'd0;
      done_in       = 2'd0;
      dropped_in    = 1'b0;
      swap_pop      = 1'b0;
      pop           = 1'b0;
      push_req      = 1'b0;
      wr_new        = wr_cnt;
      rd_new        = rd_cnt;
      side_in       = side_ff;
      do_we         = 1'b0;
      do_re         = 1'b0;
      raddr         = {~side_ff, rd_dec[IDX_W-1:0]};

      case (req.action)
         sser_pkg::ACT_RX: begin
            tx_load_in = 1'b1;
            case (mode_ff)
               sser_pkg::MODE_IDLE: begin
                  if (req.rx_byte == cmds.simple) begin
                     if (wr_cnt != '0) begin
                        swap_pop = 1'b1;
                        mode_in  = sser_pkg::MODE_SIMPLE;
                     end else begin
                        tx_in = 8'(wr_cnt);
                     end
                  end else if (req.rx_byte == cmds.led) begin
                     swap_pop      = 1'b1;
                     mode_in       = sser_pkg::MODE_LED;
                     bytes_left_in = sser_pkg::LED_BYTES;
                  end else if (req.rx_byte == cmds.lcd_top) begin
                     swap_pop      = 1'b1;
                     mode_in       = sser_pkg::MODE_LCD_TOP;
                     bytes_left_in = sser_pkg::LCD_BYTES;
                  end else if (req.rx_byte == cmds.lcd_bottom) begin
                     swap_pop      = 1'b1;
                     mode_in       = sser_pkg::MODE_LCD_BOTTOM;
                     bytes_left_in = sser_pkg::LCD_BYTES;
                  end else if (req.rx_byte == cmds.dip) begin
                     tx_in   = req.dip_value;
                     mode_in = sser_pkg::MODE_DIP;
                  end else begin
                     tx_in = 8'(wr_cnt);
                  end
               end
               sser_pkg::MODE_SIMPLE: begin
                  if (rd_cnt == '0) begin
                     tx_in   = 8'(wr_cnt);
                     mode_in = sser_pkg::MODE_IDLE;
                  end else begin
                     pop = 1'b1;
                  end
               end
               sser_pkg::MODE_LED, sser_pkg::MODE_LCD_TOP, sser_pkg::MODE_LCD_BOTTOM: begin
                  bytes_left_in = bl_dec;
                  if (bl_dec == 5'd0) begin
                     done_in = 2'(mode_ff - 3'd1);
                     mode_in = sser_pkg::MODE_IDLE;
                     tx_in   = 8'(wr_cnt);
                  end else begin
                     pop = 1'b1;
                  end
                  st_valid_in = 1'b1;
                  st_idx_in   = bl_dec[3:0];
                  st_byte_in  = req.rx_byte;
               end
               default: begin
                  mode_in = sser_pkg::MODE_IDLE;
                  tx_in   = 8'(wr_cnt);
               end
            endcase
         end
         sser_pkg::ACT_EVENT, sser_pkg::ACT_ENCODER: begin
            // a zero key byte means no event
            push_req = (req.action == sser_pkg::ACT_ENCODER) || (req.event_byte != 8'd0);
         end
         default: ;
      endcase

      // the old write stack becomes the read stack and gives its top entry
      if (swap_pop && wr_cnt != '0) begin
         side_in     = ~side_ff;
         wr_new      = wr_dec;
         do_re       = 1'b1;
         raddr       = {side_ff, wr_dec[IDX_W-1:0]};
         from_mem_in = 1'b1;
      end

      if (pop && rd_cnt != '0) begin
         rd_new      = rd_dec;
         do_re       = 1'b1;
         from_mem_in = 1'b1;
      end

      if (push_req) begin
         if (wr_cnt >= DEPTH_CNT) begin
            dropped_in = 1'b1;
         end else begin
            do_we  = 1'b1;
            wr_new = wr_cnt + CNT_ONE;
            if (mode_ff == sser_pkg::MODE_IDLE) begin
               tx_load_in = 1'b1;
               tx_in      = 8'(wr_cnt) + 8'd1;
            end
         end
      end

      if (side_ff) begin
         cnt_a_in = wr_new;
         cnt_b_in = rd_new;
      end else begin
         cnt_a_in = rd_new;
         cnt_b_in = wr_new;
      end
   end

   assign mem_we    = accept && do_we;
   assign mem_waddr = {side_ff, wr_cnt[IDX_W-1:0]};
   assign mem_wdata = push_val;
   assign mem_re    = accept && do_re;
   assign mem_raddr = raddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= sser_pkg::MODE_IDLE;
         bytes_left_ff <= 5'd0;
         side_ff       <= 1'b1;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            bytes_left_ff <= bytes_left_in;
            side_ff       <= side_in;
            cnt_a_ff      <= cnt_a_in;
            cnt_b_ff      <= cnt_b_in;
            valid_ff      <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tx_load_ff  <= tx_load_in;
         tx_ff       <= tx_in;
         from_mem_ff <= from_mem_in;
         st_valid_ff <= st_valid_in;
         st_idx_ff   <= st_idx_in;
         st_byte_ff  <= st_byte_in;
         done_ff     <= done_in;
         dropped_ff  <= dropped_in;
      end
   end

   // popped bytes arrive from the memory read register
   assign rsp.valid         = valid_ff;
   assign rsp.tx_load       = tx_load_ff;
   assign rsp.tx_byte       = from_mem_ff ? mem_rdata : tx_ff;
   assign rsp.store_valid   = st_valid_ff;
   assign rsp.store_index   = st_idx_ff;
   assign rsp.store_byte    = st_byte_ff;
   assign rsp.frame_done    = done_ff;
   assign rsp.event_dropped = dropped_ff;

endmodule
